// ===== hw/rtl/wsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame parser package
// Shared types and constants for the frame parser and its checker.
// ----------------------------------------------------------------------------
package wsfp_pkg;

   localparam int unsigned CAP_W = 16;
   localparam logic [CAP_W-1:0] CAP_RESET = 16'd1024;

   localparam logic [3:0] OPCODE_MASK = 4'hF;
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES = 4'd4;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXTLEN,
      PH_KEY,
      PH_PAYLOAD
   } wsfp_phase_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [3:0] frame_opcode;
      logic       last_of_frame;
      logic       empty_frame;
      logic       was_truncated;
   } wsfp_result_type;

endpackage

// ===== hw/rtl/wsfp_parser.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame parser core
// Holds the header and payload state and decodes one stream byte per cycle.
// ----------------------------------------------------------------------------
module wsfp_parser
   import wsfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  logic [7:0]       rx_byte,
   input  logic [CAP_W-1:0] payload_cap,
   output logic             res_valid,
   output wsfp_result_type  res
);

   localparam int unsigned POS_W = CAP_W + 1;
   localparam logic [POS_W-1:0] POS_SAT = {1'b1, {CAP_W{1'b0}}};

   wsfp_phase_type phase_ff, phase_in;
   logic [3:0]       opcode_ff, opcode_in;
   logic             mask_ff, mask_in;
   logic [63:0]      len_ff, len_in;
   logic [63:0]      remaining_ff, remaining_in;
   logic [3:0]       count_ff, count_in;
   logic [31:0]      key_ff, key_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic             len_done;
   logic             len_done_mask;
   logic             len_done_zero;
   logic [6:0]       len7;
   logic [63:0]      len_shifted;
   logic [POS_W-1:0] cap_ext;
   logic [7:0]       key_byte;
   logic             emit;
   logic             trunc;

   assign len7 = rx_byte[6:0];
   assign len_shifted = {len_ff[55:0], rx_byte};
   assign cap_ext = {1'b0, payload_cap};
   assign key_byte = key_ff[{~pos_ff[1:0], 3'b000} +: 8];
   assign emit = pos_ff < cap_ext;
   assign trunc = (|len_ff[63:CAP_W]) || (len_ff[CAP_W-1:0] > payload_cap);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         opcode_ff <= '0;
         mask_ff <= 1'b0;
         len_ff <= '0;
         remaining_ff <= '0;
         count_ff <= '0;
         key_ff <= '0;
         pos_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         opcode_ff <= opcode_in;
         mask_ff <= mask_in;
         len_ff <= len_in;
         remaining_ff <= remaining_in;
         count_ff <= count_in;
         key_ff <= key_in;
         pos_ff <= pos_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      opcode_in = opcode_ff;
      mask_in = mask_ff;
      len_in = len_ff;
      remaining_in = remaining_ff;
      count_in = count_ff;
      key_in = key_ff;
      pos_in = pos_ff;
      len_done = 1'b0;
      len_done_mask = mask_ff;
      len_done_zero = 1'b0;
      res_valid = 1'b0;
      res = '0;
      res.frame_opcode = opcode_ff;

      if (byte_valid) begin
         case (phase_ff)
            PH_HDR0: begin
               opcode_in = rx_byte[3:0] & OPCODE_MASK;
               phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               mask_in = rx_byte[7];
               if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                  len_in = '0;
                  count_in = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                  phase_in = PH_EXTLEN;
               end else begin
                  len_in = {57'd0, len7};
                  remaining_in = {57'd0, len7};
                  len_done = 1'b1;
                  len_done_mask = rx_byte[7];
                  len_done_zero = (len7 == 7'd0);
               end
            end
            PH_EXTLEN: begin
               len_in = len_shifted;
               remaining_in = len_shifted;
               count_in = count_ff - 4'd1;
               if (count_ff == 4'd1) begin
                  len_done = 1'b1;
                  len_done_zero = (len_shifted == 64'd0);
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], rx_byte};
               count_in = count_ff - 4'd1;
               if (count_ff == 4'd1) begin
                  if (len_ff == 64'd0) begin
                     phase_in = PH_HDR0;
                     res_valid = 1'b1;
                     res.last_of_frame = 1'b1;
                     res.empty_frame = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (emit) begin
                  res_valid = 1'b1;
                  res.payload_byte = mask_ff ? (rx_byte ^ key_byte) : rx_byte;
                  res.last_of_frame = (pos_ff + 1'b1 == cap_ext) || (remaining_ff == 64'd1);
                  res.was_truncated = trunc;
               end
               pos_in = (pos_ff == POS_SAT) ? pos_ff : pos_ff + 1'b1;
               remaining_in = remaining_ff - 64'd1;
               if (remaining_ff == 64'd1) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase

         if (len_done) begin
            pos_in = '0;
            key_in = '0;
            if (len_done_mask) begin
               count_in = KEY_BYTES;
               phase_in = PH_KEY;
            end else if (len_done_zero) begin
               phase_in = PH_HDR0;
               res_valid = 1'b1;
               res.last_of_frame = 1'b1;
               res.empty_frame = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
      end
   end

endmodule

// ===== hw/rtl/websocket_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame parser unit
// Deframes a received WebSocket byte stream into tagged payload bytes.
// ----------------------------------------------------------------------------
// The req channel takes one byte of the frame stream per transaction. Frames
// follow each other with no gap; header bytes give no result, each payload
// byte within the cap gives one rsp transaction carrying the unmasked byte,
// the frame opcode and the last, empty and truncated flags. A frame with no
// payload gives a single empty result once its header is complete.
// A result appears on rsp in the cycle after its byte is accepted. The unit takes
// one byte per cycle; the byte path is one decode step between the parser
// state and the output register. A stalled result holds in the output
// register, and req_ready stays high as long as that register is empty or
// drains in the same cycle, so a stall on rsp stalls req after one result.
// The csr channel writes payload_cap and is always ready; write it only
// while the stream is idle. Reset is synchronous: it empties the output
// register, sets payload_cap to 1024 and waits for the first header byte.
// ----------------------------------------------------------------------------
module websocket_frame_parser_unit
   import wsfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_payload_byte,
   output logic [3:0]       rsp_frame_opcode,
   output logic             rsp_last_of_frame,
   output logic             rsp_empty_frame,
   output logic             rsp_was_truncated,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_payload_cap
);

   logic [CAP_W-1:0] cap_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   wsfp_result_type  rsp_ff;
   logic             req_accept;
   logic             res_valid;
   wsfp_result_type  res;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready = 1'b1;

   wsfp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_accept),
      .rx_byte     (req_rx_byte),
      .payload_cap (cap_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   always_comb begin
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_payload_cap;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_frame_opcode = rsp_ff.frame_opcode;
   assign rsp_last_of_frame = rsp_ff.last_of_frame;
   assign rsp_empty_frame = rsp_ff.empty_frame;
   assign rsp_was_truncated = rsp_ff.was_truncated;

endmodule

// ===== hw/rtl/wsfp_checker.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame parser checker
// Port-level assertions on the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module wsfp_checker
   import wsfp_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [7:0]       rsp_payload_byte,
   input logic             rsp_last_of_frame,
   input logic             rsp_empty_frame,
   input logic             rsp_was_truncated
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Stalled response transaction was dropped.");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_frame |->
         rsp_last_of_frame && rsp_payload_byte == 8'd0 && !rsp_was_truncated)
      else $error("Empty-frame result carries payload or flags.");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("Response appeared without an accepted request byte.");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Request channel stalled while the output is empty.");

endmodule

bind websocket_frame_parser_unit wsfp_checker u_wsfp_checker (.*);
